// ----- sv/crcfpr_pkg.sv -----
// Shared types, constants and the byte-wide CRC function for the framed packet receiver.
package crcfpr_pkg;

	localparam int unsigned MAX_PAYLOAD_DEF = 8;
	localparam int unsigned PAYLOAD_W       = 64;
	localparam int unsigned PAYLOAD_BYTES   = PAYLOAD_W / 8;
	localparam int unsigned CFG_IDX_W       = 2;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h8408;
	localparam logic [7:0]  MODE_BASE = 8'hFF;

	localparam logic [CFG_IDX_W-1:0] REG_REQUEST_HEADER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COMMAND_HEADER = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPECIAL_HEADER = 2'd2;

	localparam logic [7:0] REQUEST_HEADER_RST = 8'd1;
	localparam logic [7:0] COMMAND_HEADER_RST = 8'd2;
	localparam logic [7:0] SPECIAL_HEADER_RST = 8'd3;

	typedef enum logic [2:0] {
		EV_NONE    = 3'd0,
		EV_GOOD    = 3'd1,
		EV_CRC_ERR = 3'd2,
		EV_LEN_ERR = 3'd3,
		EV_ACK     = 3'd4
	} event_t;

	typedef struct packed {
		logic [7:0] request_header;
		logic [7:0] command_header;
		logic [7:0] special_header;
	} hdr_cfg_t;

	typedef struct packed {
		event_t                 event_res;
		logic [7:0]             frame_mode;
		logic [7:0]             frame_id;
		logic [3:0]             frame_length;
		logic [PAYLOAD_W-1:0]   payload;
		logic [7:0]             ack_code;
		logic [15:0]            computed_crc;
	} result_t;

	// Reflected CRC-16 over one byte, LSB first.
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ----- sv/crc16_framed_packet_receiver.sv -----
// Top level of the CRC-16 framed packet receiver: header registers, parser and result register.
//
//  channel  handshake            payload
//  -------  -------------------  ------------------------------------------------
//  in       in_valid/in_ready    rx_byte, ack_pending
//  out      out_valid/out_ready  event_res, frame_mode, frame_id, frame_length,
//                                payload, ack_code, computed_crc
//  cfg      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One word per cycle while in_ready is high: each accepted word gives one result word in
// the next cycle; byte-wide CRC and phase logic sit between parser state and result register.
// Reset clears the parser to header search with CRC 0xFFFF and loads the default headers.
// in_ready drops only while a result is held and out_ready is low; cfg_ready is always high.
module crc16_framed_packet_receiver #(
	parameter int unsigned MAX_PAYLOAD = crcfpr_pkg::MAX_PAYLOAD_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [7:0]                            rx_byte,
	input  logic                                  ack_pending,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [2:0]                            event_res,
	output logic [7:0]                            frame_mode,
	output logic [7:0]                            frame_id,
	output logic [3:0]                            frame_length,
	output logic [crcfpr_pkg::PAYLOAD_W-1:0]      payload,
	output logic [7:0]                            ack_code,
	output logic [15:0]                           computed_crc,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [crcfpr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [7:0]                            cfg_data
);
	import crcfpr_pkg::*;

	hdr_cfg_t cfg_q;
	result_t  res_comb;
	result_t  res_out;
	logic     accept;
	logic     space;

	assign cfg_ready = 1'b1;
	assign in_ready  = space;
	assign accept    = in_valid && space;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.request_header <= REQUEST_HEADER_RST;
			cfg_q.command_header <= COMMAND_HEADER_RST;
			cfg_q.special_header <= SPECIAL_HEADER_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_REQUEST_HEADER: cfg_q.request_header <= cfg_data;
				REG_COMMAND_HEADER: cfg_q.command_header <= cfg_data;
				REG_SPECIAL_HEADER: cfg_q.special_header <= cfg_data;
				default: ; // drop writes to unmapped indexes
			endcase
		end
	end

	crcfpr_core #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.rx_byte    (rx_byte),
		.ack_pending(ack_pending),
		.cfg        (cfg_q),
		.result     (res_comb)
	);

	crcfpr_out_reg u_out (
		.clk   (clk),
		.arst_n(arst_n),
		.load  (accept),
		.din   (res_comb),
		.space (space),
		.valid (out_valid),
		.ready (out_ready),
		.dout  (res_out)
	);

	assign event_res    = res_out.event_res;
	assign frame_mode   = res_out.frame_mode;
	assign frame_id     = res_out.frame_id;
	assign frame_length = res_out.frame_length;
	assign payload      = res_out.payload;
	assign ack_code     = res_out.ack_code;
	assign computed_crc = res_out.computed_crc;

endmodule

// ----- sv/crcfpr_core.sv -----
// Frame parser: phase state, running CRC, held header fields and payload store.
module crcfpr_core #(
	parameter int unsigned MAX_PAYLOAD = crcfpr_pkg::MAX_PAYLOAD_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [7:0]           rx_byte,
	input  logic                 ack_pending,
	input  crcfpr_pkg::hdr_cfg_t cfg,
	output crcfpr_pkg::result_t  result
);
	import crcfpr_pkg::*;

	localparam int unsigned IDX_W   = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
	localparam logic [3:0]  CNT_MAX = 4'(MAX_PAYLOAD);
	localparam logic [7:0]  LEN_MAX = 8'(MAX_PAYLOAD);

	typedef enum logic [2:0] {
		PH_HEADER  = 3'd0,
		PH_ID      = 3'd1,
		PH_LENGTH  = 3'd2,
		PH_DATA    = 3'd3,
		PH_CRC_HI  = 3'd4,
		PH_CRC_LO  = 3'd5,
		PH_SPECIAL = 3'd6
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [3:0]  cnt_q, cnt_d, cnt_inc;
	logic [15:0] crc_q, crc_d;
	logic [7:0]  crc_hi_q, crc_hi_d;
	logic [7:0]  mode_q, mode_d;
	logic [7:0]  id_q, id_d;
	logic [3:0]  len_q, len_d;
	logic        store_we;
	event_t      ev;
	logic [7:0]  code;
	logic [7:0]  store_q [MAX_PAYLOAD];
	logic [7:0]  pay_b [PAYLOAD_BYTES];

	assign cnt_inc = cnt_q + 4'd1;

	always_comb begin
		phase_d  = phase_q;
		cnt_d    = cnt_q;
		crc_d    = crc_q;
		crc_hi_d = crc_hi_q;
		mode_d   = mode_q;
		id_d     = id_q;
		len_d    = len_q;
		store_we = 1'b0;
		ev       = EV_NONE;
		code     = 8'h00;
		unique case (phase_q)
			PH_HEADER: begin
				if (rx_byte == cfg.request_header || rx_byte == cfg.command_header) begin
					mode_d  = MODE_BASE - rx_byte;
					cnt_d   = 4'd0;
					crc_d   = crc_byte(CRC_INIT, rx_byte);
					phase_d = PH_ID;
				end else if (rx_byte == cfg.special_header && ack_pending) begin
					phase_d = PH_SPECIAL;
				end
			end
			PH_SPECIAL: begin
				code    = rx_byte;
				ev      = EV_ACK;
				phase_d = PH_HEADER;
			end
			PH_ID: begin
				id_d    = rx_byte;
				crc_d   = crc_byte(crc_q, rx_byte);
				phase_d = PH_LENGTH;
			end
			PH_LENGTH: begin
				if (rx_byte <= LEN_MAX) begin
					len_d   = rx_byte[3:0];
					crc_d   = crc_byte(crc_q, rx_byte);
					cnt_d   = 4'd0;
					phase_d = (rx_byte == 8'd0) ? PH_CRC_HI : PH_DATA;
				end else begin
					// length byte stays out of the CRC
					ev      = EV_LEN_ERR;
					phase_d = PH_HEADER;
				end
			end
			PH_DATA: begin
				store_we = (cnt_q < CNT_MAX);
				crc_d    = crc_byte(crc_q, rx_byte);
				if (cnt_inc >= len_q) begin
					cnt_d   = 4'd0;
					phase_d = PH_CRC_HI;
				end else begin
					cnt_d = cnt_inc;
				end
			end
			PH_CRC_HI: begin
				crc_hi_d = rx_byte;
				phase_d  = PH_CRC_LO;
			end
			PH_CRC_LO: begin
				ev      = ({crc_hi_q, rx_byte} == crc_q) ? EV_GOOD : EV_CRC_ERR;
				phase_d = PH_HEADER;
			end
			default: begin
				phase_d = PH_HEADER;
			end
		endcase
	end

	for (genvar g = 0; g < PAYLOAD_BYTES; g++) begin : g_pay
		if (g < MAX_PAYLOAD) begin : g_live
			assign pay_b[g] = (ev == EV_GOOD && 4'(g) < len_q) ? store_q[g] : 8'h00;
		end else begin : g_zero
			assign pay_b[g] = 8'h00;
		end
	end

	always_comb begin
		result.event_res    = ev;
		result.frame_mode   = mode_d;
		result.frame_id     = id_d;
		result.frame_length = len_d;
		result.ack_code     = code;
		result.computed_crc = crc_d;
		for (int i = 0; i < PAYLOAD_BYTES; i++) begin
			result.payload[8*i +: 8] = pay_b[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			cnt_q    <= 4'd0;
			crc_q    <= CRC_INIT;
			crc_hi_q <= 8'h00;
			mode_q   <= 8'h00;
			id_q     <= 8'h00;
			len_q    <= 4'd0;
		end else if (accept) begin
			phase_q  <= phase_d;
			cnt_q    <= cnt_d;
			crc_q    <= crc_d;
			crc_hi_q <= crc_hi_d;
			mode_q   <= mode_d;
			id_q     <= id_d;
			len_q    <= len_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && store_we) begin
			store_q[cnt_q[IDX_W-1:0]] <= rx_byte;
		end
	end

endmodule

// ----- sv/crcfpr_out_reg.sv -----
// Result register with valid/ready handshake toward the consumer.
module crcfpr_out_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  crcfpr_pkg::result_t din,
	output logic                space,
	output logic                valid,
	input  logic                ready,
	output crcfpr_pkg::result_t dout
);
	import crcfpr_pkg::*;

	logic    valid_q;
	result_t data_q;

	// take a new word when empty or when the held one leaves this cycle
	assign space = !valid_q || ready;
	assign valid = valid_q;
	assign dout  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= din;
		end
	end

endmodule
